// File: rtl/otq_pkg.sv
// ----------------------------------------------------------------------------
// otq_pkg
// Shared types and constants for the ordered timer queue.
// ----------------------------------------------------------------------------
package otq_pkg;

  localparam int CAPACITY     = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int FIRE_DEPTH   = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;
  localparam int FIRE_IDX_W   = $clog2(FIRE_DEPTH);
  localparam int FIRE_CNT_W   = $clog2(FIRE_DEPTH + 1);

  localparam int TIME_W = 63;
  localparam int IVAL_W = 40;
  localparam int ID_W   = 8;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ST_ADD_OK = 2'd0;
  localparam logic [1:0] ST_FIRED  = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] expire_time;
    logic [IVAL_W-1:0] repeat_interval;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   fired_id;
    logic              last;
    logic              earliest_changed;
    logic              next_valid;
    logic [TIME_W-1:0] next_expire;
  } rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0] expire;
    logic [IVAL_W-1:0] interval;
    logic [ID_W-1:0]   owner;
  } timer_t;

  typedef struct packed {
    logic   valid;
    timer_t tmr;
  } slot_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic   insert;
    logic   pop;
    timer_t key;
  } chain_op_t;

endpackage

// File: rtl/otq_cell.sv
// ----------------------------------------------------------------------------
// otq_cell
// One slot of the sorted chain: compares the broadcast key, shifts right on
// insert and left on pop.
// ----------------------------------------------------------------------------
module otq_cell (
  input  logic              clk,
  input  logic              rst,
  input  otq_pkg::chain_op_t op,
  input  logic              left_ahead,
  input  otq_pkg::slot_t    left_slot,
  input  otq_pkg::slot_t    right_slot,
  output otq_pkg::slot_t    slot,
  output logic              ahead
);

  logic            valid;
  otq_pkg::timer_t tmr;
  otq_pkg::slot_t  slot_next;

  assign slot.valid = valid;
  assign slot.tmr   = tmr;

  // key sorts strictly before this slot; empty slots sort last
  always_comb begin
    ahead = !valid ||
            (op.key.expire < tmr.expire) ||
            ((op.key.expire == tmr.expire) && (op.key.owner < tmr.owner));
  end

  always_comb begin
    slot_next = slot;
    if (op.pop) begin
      slot_next = right_slot;
    end else if (op.insert && ahead) begin
      if (left_ahead) begin
        slot_next = left_slot;
      end else begin
        slot_next.valid = 1'b1;
        slot_next.tmr   = op.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= slot_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    tmr <= slot_next.tmr;
  end

endmodule

// File: rtl/otq_chain.sv
// ----------------------------------------------------------------------------
// otq_chain
// Row of cells holding the timers in sorted order, head in cell 0.
// ----------------------------------------------------------------------------
module otq_chain (
  input  logic               clk,
  input  logic               rst,
  input  otq_pkg::chain_op_t op,
  output otq_pkg::slot_t     head,
  output logic               full
);

  otq_pkg::slot_t slots [otq_pkg::CAPACITY];
  logic           aheads[otq_pkg::CAPACITY];

  genvar k;
  generate
    for (k = 0; k < otq_pkg::CAPACITY; k++) begin : g_cell
      logic           lb;
      otq_pkg::slot_t ls;
      otq_pkg::slot_t rs;

      if (k == 0) begin : g_first
        assign lb = 1'b0;
        assign ls = '0;
      end else begin : g_mid
        assign lb = aheads[k-1];
        assign ls = slots[k-1];
      end

      if (k == otq_pkg::CAPACITY - 1) begin : g_last
        assign rs = '0;
      end else begin : g_inner
        assign rs = slots[k+1];
      end

      otq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .op        (op),
        .left_ahead(lb),
        .left_slot (ls),
        .right_slot(rs),
        .slot      (slots[k]),
        .ahead     (aheads[k])
      );
    end
  endgenerate

  assign head = slots[0];
  assign full = slots[otq_pkg::CAPACITY-1].valid;

endmodule

// File: rtl/ordered_timer_queue.sv
// ----------------------------------------------------------------------------
// ordered_timer_queue
// Timer queue kept sorted by expiry then id in a shifting chain of cells.
//
//   channel  signals                    direction  payload
//   req      req_valid/req_ready/req    in         otq_pkg::req_t
//   rsp      rsp_valid/rsp_ready/rsp    out        otq_pkg::rsp_t
//
// Add: inserted unless the chain is full, and its result registered at the
//   transfer edge; a new add can follow every cycle while results are taken.
// Tick: pops and stages each fired timer, closes the scan, reinserts each
//   repeating timer, then gives one result per cycle while results are taken.
// Reset clears the chain valid bits and the control state only.
// A stalled rsp holds everything; no req is taken until the tick finishes.
// ----------------------------------------------------------------------------
module ordered_timer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  otq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output otq_pkg::rsp_t  rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIRE  = 2'd1;
  localparam logic [1:0] S_REINS = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [otq_pkg::FIRE_CNT_W-1:0] CNT_MAX =
    otq_pkg::FIRE_CNT_W'(otq_pkg::FIRE_DEPTH);

  logic [1:0]                      state, state_next;
  logic [otq_pkg::FIRE_CNT_W-1:0]  cnt, cnt_next;
  logic [otq_pkg::FIRE_IDX_W-1:0]  rd, rd_next;
  logic                            rsp_valid_next;
  logic [otq_pkg::TIME_W-1:0]      now;

  logic [otq_pkg::ID_W-1:0]        fire_id [otq_pkg::FIRE_DEPTH];
  logic [otq_pkg::IVAL_W-1:0]      fire_iv [otq_pkg::FIRE_DEPTH];
  logic [otq_pkg::TIME_W-1:0]      fire_due[otq_pkg::FIRE_DEPTH];
  logic                            fire_rep[otq_pkg::FIRE_DEPTH];

  logic [1:0]                      rsp_status, rsp_status_next;
  logic [otq_pkg::ID_W-1:0]        rsp_id, rsp_id_next;
  logic                            rsp_last, rsp_last_next;
  logic                            rsp_ec, rsp_ec_next;
  logic                            rsp_load;

  otq_pkg::chain_op_t              op;
  otq_pkg::slot_t                  head;
  logic                            full;

  logic                            req_xfer;
  logic                            out_free;
  logic                            fire_take;
  logic                            rd_last;
  logic [otq_pkg::TIME_W:0]        due_sum;
  logic [otq_pkg::TIME_W-1:0]      due_sat;

  otq_chain u_chain (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .head(head),
    .full(full)
  );

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign req_xfer  = req_valid && req_ready;

  assign fire_take = (state == S_FIRE) && head.valid && (head.tmr.expire <= now) &&
                     (cnt != CNT_MAX);
  assign rd_last   = (otq_pkg::FIRE_CNT_W'(rd) + 1'b1) == cnt;

  assign due_sum = {1'b0, now} + (otq_pkg::TIME_W + 1)'(head.tmr.interval);
  assign due_sat = due_sum[otq_pkg::TIME_W] ? '1 : due_sum[otq_pkg::TIME_W-1:0];

  always_comb begin
    op = '0;
    unique case (state)
      S_IDLE: begin
        op.insert       = req_xfer && (req.cmd == otq_pkg::CMD_ADD) && !full;
        op.key.expire   = req.expire_time;
        op.key.interval = req.repeat_interval;
        op.key.owner    = req.timer_id;
      end
      S_FIRE: begin
        op.pop = fire_take;
      end
      S_REINS: begin
        op.insert       = fire_rep[rd];
        op.key.expire   = fire_due[rd];
        op.key.interval = fire_iv[rd];
        op.key.owner    = fire_id[rd];
      end
      default: begin
        op = '0;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    rd_next         = rd;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    rsp_load        = 1'b0;
    rsp_status_next = otq_pkg::ST_ADD_OK;
    rsp_id_next     = '0;
    rsp_last_next   = 1'b1;
    rsp_ec_next     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          if (req.cmd == otq_pkg::CMD_ADD) begin
            rsp_load        = 1'b1;
            rsp_status_next = full ? otq_pkg::ST_FULL : otq_pkg::ST_ADD_OK;
            rsp_ec_next     = !full &&
                              (!head.valid || (req.expire_time < head.tmr.expire));
          end else begin
            state_next = S_FIRE;
            cnt_next   = '0;
          end
        end
      end
      S_FIRE: begin
        if (fire_take) begin
          cnt_next = cnt + 1'b1;
        end else if (cnt == '0) begin
          rsp_load        = 1'b1;
          rsp_status_next = otq_pkg::ST_NONE;
          state_next      = S_IDLE;
        end else begin
          rd_next    = '0;
          state_next = S_REINS;
        end
      end
      S_REINS: begin
        if (rd_last) begin
          rd_next    = '0;
          state_next = S_EMIT;
        end else begin
          rd_next = rd + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          rsp_load        = 1'b1;
          rsp_status_next = otq_pkg::ST_FIRED;
          rsp_id_next     = fire_id[rd];
          rsp_last_next   = rd_last;
          if (rd_last) begin
            state_next = S_IDLE;
          end else begin
            rd_next = rd + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rd        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rd        <= rd_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      now <= req.now_time;
    end
    if (fire_take) begin
      fire_id [cnt[otq_pkg::FIRE_IDX_W-1:0]] <= head.tmr.owner;
      fire_iv [cnt[otq_pkg::FIRE_IDX_W-1:0]] <= head.tmr.interval;
      fire_due[cnt[otq_pkg::FIRE_IDX_W-1:0]] <= due_sat;
      fire_rep[cnt[otq_pkg::FIRE_IDX_W-1:0]] <= head.tmr.interval != '0;
    end
    if (rsp_load) begin
      rsp_status <= rsp_status_next;
      rsp_id     <= rsp_id_next;
      rsp_last   <= rsp_last_next;
      rsp_ec     <= rsp_ec_next;
    end
  end

  // next expiry read live from the chain head, which holds while results wait
  always_comb begin
    rsp.status           = rsp_status;
    rsp.fired_id         = rsp_id;
    rsp.last             = rsp_last;
    rsp.earliest_changed = rsp_ec;
    rsp.next_valid       = head.valid;
    rsp.next_expire      = head.valid ? head.tmr.expire : '0;
  end

  a_add_result: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && (req.cmd == otq_pkg::CMD_ADD)) |=> rsp_valid)
    else $error("add transfer without result");

  a_mid_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_last) |-> (state == S_EMIT))
    else $error("non-final result outside emit");

  a_head_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> ($stable(rsp.next_valid) && $stable(rsp.next_expire)))
    else $error("chain moved while results pending");

  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    full |-> head.valid)
    else $error("chain holds a gap");

endmodule
